// ===== design/stepper_accel_step_timer_core_macros.svh =====
// Assertion macros for the stepper step timer core.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef STEPPER_ACCEL_STEP_TIMER_CORE_MACROS_SVH
`define STEPPER_ACCEL_STEP_TIMER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SAST_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SAST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/sast_pkg.sv =====
// Shared widths, constants and fault codes for the stepper step timer.
// No dependencies.
package sast_pkg;

  localparam int TimeWidthDefault = 32;
  localparam int V0W   = 16;
  localparam int AW    = 21;
  localparam int IDXW  = 20;
  localparam int XW    = 21;
  localparam int OUTW  = 24;
  localparam int PWW   = 8;
  localparam int RADW  = 64;
  localparam int ROOTW = 32;
  localparam int DENW  = 33;
  localparam int DVDW  = 52;

  localparam logic [OUTW-1:0] OutMax     = 24'hFFFFFF;
  localparam logic [PWW-1:0]  PulseReset = 8'd15;
  // 2 * 1e6 us/s scaled by 2^10 for the Q.10 root.
  localparam logic [30:0]     NumScale   = 31'd2048000000;

  localparam logic [1:0] FaultNone = 2'd0;
  localparam logic [1:0] FaultIdle = 2'd1;
  localparam logic [1:0] FaultStop = 2'd2;

endpackage

// ===== design/stepper_accel_step_timer_core.sv =====
// Stepper step timer with constant acceleration. One step request gives one
// result: the time of step x = index + 1, t = 2x / (v0 + sqrt(v0^2 + 2ax)), in
// whole microseconds, the interval since the previous step, the low time after
// the pulse and a last-step mark. A request goes from accept through two setup
// states, the two-bit-per-cycle square root of 32 digits, a state that forms
// the divisor, the bit-serial divider for the 52 quotient bits and two
// finishing states; the last of these waits while the output is stalled.
// Requests with no motion or with a negative discriminant skip both units and
// go from setup straight to the last finishing state. One request is worked
// on at a time; a new one is taken while the previous result still waits on
// the output. Depends on sast_pkg, sast_isqrt, sast_div and the macros header.
module stepper_accel_step_timer_core
  import sast_pkg::*;
#(
  parameter int TIME_WIDTH = TimeWidthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,    // pulse_width_us
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // start_speed, accel_rate, move_steps
  input  logic        s_axis_tuser,   // start_move
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // interval_us, low_time_us, step_number
  output logic        m_axis_tlast,   // last_step
  output logic [1:0]  m_axis_tuser    // fault
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_SETUP = 3'd2;
  localparam logic [2:0] S_SQRT  = 3'd3;
  localparam logic [2:0] S_DEN   = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_TIME  = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  logic [2:0]            state_q, state_d;
  logic [PWW-1:0]        pw_q;
  logic [IDXW-1:0]       step_index_q, idx_q;
  logic [TIME_WIDTH-1:0] prev_q, t_q;
  logic [V0W-1:0]        v0_q;
  logic signed [AW-1:0]  a_q;
  logic [IDXW-1:0]       steps_q;
  logic [XW-1:0]         x_q;
  logic [31:0]           v0sq_q;
  logic signed [42:0]    ax_q;
  logic [DVDW-1:0]       num_q;
  logic [1:0]            fault_q;
  logic [OUTW-1:0]       interval_q;
  logic                  in_acc, out_free;

  // Output register.
  logic                  out_valid_q;
  logic [OUTW-1:0]       o_int_q, o_low_q;
  logic [IDXW-1:0]       o_idx_q;
  logic                  o_last_q;
  logic [1:0]            o_fault_q;

  // Units.
  logic                  sq_start, sq_busy, sq_done, dv_start, dv_busy, dv_done;
  logic [RADW-1:0]       rad;
  logic [ROOTW-1:0]      root;
  logic [DENW-1:0]       den;
  logic [DVDW-1:0]       dvd, quo;

  // Setup arithmetic.
  logic signed [44:0]    v0e, axe, d;
  logic                  last;
  logic                  ovf;
  logic [TIME_WIDTH-1:0] t_sat, diff;
  logic [OUTW-1:0]       low;

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign out_free      = !out_valid_q || m_axis_tready;

  // Discriminant, root and divider operands.
  always_comb begin
    v0e  = {13'b0, v0sq_q};
    axe  = {{2{ax_q[42]}}, ax_q};
    d    = v0e + (axe <<< 1);
    rad  = {1'b0, d[42:0], 20'b0};
    den  = (DENW'(v0_q) << 10) + DENW'(root);
    dvd  = num_q + DVDW'(den >> 1);
    ovf  = |(quo >> TIME_WIDTH);
    t_sat = ovf ? '1 : quo[TIME_WIDTH-1:0];
    diff = t_sat - prev_q;
    last = (x_q >= {1'b0, steps_q});
    low  = (interval_q > OUTW'(pw_q)) ? (interval_q - OUTW'(pw_q)) : '0;
  end

  // Sequencer.
  always_comb begin
    state_d  = state_q;
    sq_start = 1'b0;
    dv_start = 1'b0;
    case (state_q)
      S_IDLE:  if (in_acc) state_d = S_MUL;
      S_MUL:   state_d = S_SETUP;
      S_SETUP: begin
        if ((v0_q == '0 && a_q == '0) || d < 0) begin
          state_d = S_FIN;
        end else begin
          sq_start = 1'b1;
          state_d  = S_SQRT;
        end
      end
      S_SQRT:  if (sq_done) state_d = S_DEN;
      S_DEN: begin
        if (den == '0) begin
          state_d = S_FIN;
        end else begin
          dv_start = 1'b1;
          state_d  = S_DIV;
        end
      end
      S_DIV:   if (dv_done) state_d = S_TIME;
      S_TIME:  state_d = S_FIN;
      S_FIN:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  sast_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(sq_start),
    .rad_i  (rad),
    .busy_o (sq_busy),
    .done_o (sq_done),
    .root_o (root)
  );

  sast_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(dv_start),
    .dvd_i  (dvd),
    .den_i  (den),
    .busy_o (dv_busy),
    .done_o (dv_done),
    .quo_o  (quo)
  );

  // Control state, move state and the output register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      pw_q         <= PulseReset;
      step_index_q <= '0;
      prev_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) pw_q <= cfg_wdata_i;
      if (in_acc && s_axis_tuser) begin
        step_index_q <= '0;
        prev_q       <= '0;
      end
      if (state_q == S_FIN && out_free) begin
        out_valid_q <= 1'b1;
        if (last) begin
          step_index_q <= '0;
          prev_q       <= '0;
        end else begin
          step_index_q <= x_q[IDXW-1:0];
          if (fault_q == FaultNone) prev_q <= t_q;
        end
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item datapath.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          v0_q    <= s_axis_tdata[15:0];
          a_q     <= s_axis_tdata[36:16];
          steps_q <= s_axis_tdata[56:37];
          idx_q   <= s_axis_tuser ? '0 : step_index_q;
        end
      end
      S_MUL: begin
        x_q    <= XW'(idx_q) + XW'(1);
        v0sq_q <= v0_q * v0_q;
        ax_q   <= 43'(a_q * $signed({2'b0, idx_q} + 22'sd1));
        num_q  <= DVDW'((XW'(idx_q) + XW'(1)) * NumScale);
      end
      S_SETUP: begin
        interval_q <= OutMax;
        if (v0_q == '0 && a_q == '0) fault_q <= FaultIdle;
        else if (d < 0)              fault_q <= FaultStop;
        else                         fault_q <= FaultNone;
      end
      S_DEN: if (den == '0) fault_q <= FaultStop;
      S_TIME: begin
        t_q <= t_sat;
        if (t_sat < prev_q)              interval_q <= '0;
        else if (diff > TIME_WIDTH'(OutMax)) interval_q <= OutMax;
        else                             interval_q <= diff[OUTW-1:0];
      end
      S_FIN: begin
        if (out_free) begin
          o_int_q   <= interval_q;
          o_low_q   <= low;
          o_idx_q   <= idx_q;
          o_last_q  <= last;
          o_fault_q <= fault_q;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, o_idx_q, o_low_q, o_int_q};
  assign m_axis_tlast  = o_last_q;
  assign m_axis_tuser  = o_fault_q;

`include "stepper_accel_step_timer_core_macros.svh"

  `SAST_ASSERT_SAME(a_fault_sat, m_axis_tvalid && m_axis_tuser != FaultNone, m_axis_tdata[23:0] == OutMax, "faulted item without saturated interval")
  `SAST_ASSERT_SAME(a_low_le_int, m_axis_tvalid, m_axis_tdata[47:24] <= m_axis_tdata[23:0], "low time above interval")
  `SAST_ASSERT_SAME(a_units_excl, sq_busy, !dv_busy, "root and divider busy together")
  `SAST_ASSERT_NEXT(a_acc_start, in_acc, state_q == S_MUL && !s_axis_tready, "accepted item did not start")

endmodule

// ===== design/sast_isqrt.sv =====
// Digit-serial integer square root, two radicand bits per cycle.
// Depends on sast_pkg.
module sast_isqrt
  import sast_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [RADW-1:0]  rad_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [ROOTW-1:0] root_o
);

  logic [RADW-1:0]  rad_q;
  logic [ROOTW+2:0] rem_q, rem_sh, trial;
  logic [ROOTW-1:0] root_q;
  logic [4:0]       cnt_q;
  logic             busy_q, done_q, ge;

  // One root digit: bring down two bits and try to subtract 4q+1.
  always_comb begin
    rem_sh = {rem_q[ROOTW:0], rad_q[RADW-1 -: 2]};
    trial  = {1'b0, root_q, 2'b01};
    ge     = (rem_sh >= trial);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'd31;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath shift registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[RADW-3:0], 2'b00};
      rem_q  <= ge ? (rem_sh - trial) : rem_sh;
      root_q <= {root_q[ROOTW-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ===== design/sast_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on sast_pkg.
module sast_div
  import sast_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DVDW-1:0] dvd_i,
  input  logic [DENW-1:0] den_i,
  output logic            busy_o,
  output logic            done_o,
  output logic [DVDW-1:0] quo_o
);

  logic [DVDW-1:0] dvd_q;
  logic [DENW-1:0] den_q;
  logic [DENW:0]   rem_q, rem_sh;
  logic [5:0]      cnt_q;
  logic            busy_q, done_q, ge;

  // Shift in the next dividend bit and try the subtract.
  always_comb begin
    rem_sh = {rem_q[DENW-1:0], dvd_q[DVDW-1]};
    ge     = (rem_sh >= {1'b0, den_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'(DVDW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Quotient bits replace the dividend bits as they shift out.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dvd_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DVDW-2:0], ge};
      rem_q <= ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = dvd_q;

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the stepper step timer core.
// Depends on sast_pkg and the core; drives requests over the stream ports.
`timescale 1ns / 1ps

module testbench;
  import sast_pkg::*;

  typedef struct {
    logic        start;
    logic [15:0] speed;
    logic [20:0] accel;
    logic [19:0] steps;
  } step_req_t;

  typedef struct {
    logic [23:0] interval;
    logic [23:0] low;
    logic [19:0] step_num;
    logic        last;
    logic [1:0]  fault;
  } step_timing_t;

  // Step timing predictor and the queue of timings still due from the core.
  class step_timing_board;
    step_timing_t      due_q[$];
    logic [7:0]        pulse_w;
    longint unsigned   idx;
    longint unsigned   prev_us;
    int                errors;

    function new();
      pulse_w = PulseReset;
      idx     = 0;
      prev_us = 0;
      errors  = 0;
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root;
      longint unsigned b;
      root = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= root + b) begin
          v = v - (root + b);
          root = (root >> 1) + b;
        end else begin
          root = root >> 1;
        end
        b = b >> 2;
      end
      return root;
    endfunction

    // Works out the timing of one accepted request and advances the move state.
    function void note_request(step_req_t r);
      step_timing_t    e;
      longint          v0, a, disc;
      longint unsigned x, root, den, num, t, ival;
      if (r.start) begin
        idx = 0;
        prev_us = 0;
      end
      v0 = longint'(r.speed);
      a  = longint'($signed(r.accel));
      x  = idx + 1;
      disc = v0 * v0 + 2 * a * longint'(x);
      e.fault = FaultNone;
      ival = 0;
      if (v0 == 0 && a == 0) begin
        e.fault = FaultIdle;
      end else if (disc < 0) begin
        e.fault = FaultStop;
      end else begin
        root = int_sqrt(longint'(disc) << 20);
        den  = (longint'(v0) << 10) + root;
        if (den == 0) begin
          e.fault = FaultStop;
        end else begin
          num = 64'd2048000000 * x;
          t = (num + den / 2) / den;
          if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF;
          ival = (t >= prev_us) ? t - prev_us : 0;
          if (ival > 64'hFF_FFFF) ival = 64'hFF_FFFF;
          prev_us = t;
        end
      end
      if (e.fault != FaultNone) ival = 64'hFF_FFFF;
      e.interval = ival[23:0];
      e.low      = (ival > pulse_w) ? 24'(ival - pulse_w) : 24'd0;
      e.step_num = idx[19:0];
      e.last     = (x >= longint'(r.steps));
      if (e.last) begin
        idx = 0;
        prev_us = 0;
      end else begin
        idx = x & 64'hF_FFFF;
      end
      due_q.push_back(e);
    endfunction

    // Compares one accepted result with the oldest timing due.
    function void check_result(step_timing_t got);
      step_timing_t e;
      if (due_q.size() == 0) begin
        $display("%0t: result with none due: interval %0d", $time, got.interval);
        errors++;
        return;
      end
      e = due_q.pop_front();
      if (got.interval !== e.interval) begin
        $display("%0t: interval exp %0d got %0d", $time, e.interval, got.interval);
        errors++;
      end
      if (got.low !== e.low) begin
        $display("%0t: low time exp %0d got %0d", $time, e.low, got.low);
        errors++;
      end
      if (got.step_num !== e.step_num) begin
        $display("%0t: step number exp %0d got %0d", $time, e.step_num, got.step_num);
        errors++;
      end
      if (got.last !== e.last) begin
        $display("%0t: last step exp %0b got %0b", $time, e.last, got.last);
        errors++;
      end
      if (got.fault !== e.fault) begin
        $display("%0t: fault exp %0d got %0d", $time, e.fault, got.fault);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [7:0]  cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic [1:0]  m_axis_tuser;

  step_timing_board board;
  bit               steady;
  int               sent;

  stepper_accel_step_timer_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Run limit well beyond the slowest correct run.
  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

  function automatic bit idle_now();
    return !steady && ($urandom_range(99) < 19);
  endfunction

  // Offers one request and waits until the core takes it.
  task automatic send_request(step_req_t r);
    @(negedge clk_i);
    while (idle_now()) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = r.start;
    s_axis_tdata  = {7'd0, r.steps, r.accel, r.speed};
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_request(r);
    sent++;
  endtask

  // Lowers valid and waits until every result due has come back.
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (board.due_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_pulse(logic [7:0] w);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = w;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    board.pulse_w = w;
  endtask

  task automatic send_fields(bit st, int sp, int ac, int n);
    step_req_t r;
    r.start = st;
    r.speed = sp[15:0];
    r.accel = ac[20:0];
    r.steps = n[19:0];
    send_request(r);
  endtask

  function automatic step_req_t random_request();
    step_req_t r;
    r.start = $urandom_range(1);
    r.speed = $urandom();
    r.accel = $urandom();
    r.steps = $urandom();
    return r;
  endfunction

  // One move: a start request and then steps with the same profile, at times
  // with a changed profile or a stray request mixed in.
  task automatic random_move();
    step_req_t r;
    int        n, count;
    r.start = 1'b1;
    case ($urandom_range(3))
      0: r.speed = $urandom_range(100);
      1: r.speed = 16'd0;
      default: r.speed = $urandom();
    endcase
    case ($urandom_range(4))
      0: r.accel = 21'd0;
      1: r.accel = 21'($signed($urandom_range(2000)) - 1000);
      2: r.accel = 21'($signed($urandom_range(20)) - 10);
      default: r.accel = $urandom();
    endcase
    if ($urandom_range(9) == 0) r.steps = $urandom();
    else r.steps = $urandom_range(12, 1);
    n = (r.steps > 12) ? $urandom_range(12, 1) : int'(r.steps);
    for (count = 0; count < n; count++) begin
      if ($urandom_range(19) == 0) send_request(random_request());
      else begin
        if ($urandom_range(19) == 0) begin
          r.speed = $urandom_range(3);
          r.accel = $urandom_range(1) ? 21'd0 : 21'($urandom());
        end
        send_request(r);
        r.start = 1'b0;
      end
    end
  endtask

  task automatic random_phase(int num);
    int goal;
    goal = sent + num;
    while (sent < goal) random_move();
  endtask

  // Result side: random stalls, check on every accepted result.
  initial begin
    step_timing_t got;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready = !idle_now();
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got.interval = m_axis_tdata[23:0];
        got.low      = m_axis_tdata[47:24];
        got.step_num = m_axis_tdata[67:48];
        got.last     = m_axis_tlast;
        got.fault    = m_axis_tuser;
        board.check_result(got);
      end
    end
  end

  initial begin
    board         = new();
    steady        = 1'b0;
    sent          = 0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = 8'd0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 64'd0;
    s_axis_tuser  = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: extremes, both faults, last-step handling, time going back
    // and a saturated interval, all under the reset pulse width.
    send_fields(1, 0, 0, 3);                 // no motion
    send_fields(0, 0, 0, 3);
    send_fields(0, 0, 0, 3);
    send_fields(1, 10, -100, 5);             // stops before the step
    send_fields(1, 65535, 1048575, 1048575);
    send_fields(0, 65535, -1048576, 1048575);
    send_fields(1, 1, 0, 4);
    send_fields(0, 65535, 0, 4);             // time goes backwards
    send_fields(0, 0, 1, 4);
    send_fields(1, 0, 1, 0);                 // zero-length move
    send_fields(0, 0, 1, 0);
    send_fields(1, 65535, 0, 40);
    repeat (18) send_fields(0, 65535, 0, 40);
    send_fields(0, 1, 0, 40);                // saturated interval
    send_fields(0, 2, -1, 40);
    drain();

    write_pulse(8'd0);
    random_phase(550);
    drain();
    write_pulse(8'd255);
    steady = 1'b1;
    random_phase(200);
    steady = 1'b0;
    random_phase(400);
    drain();
    write_pulse($urandom_range(254, 1));
    random_phase(550);
    drain();

    repeat (200) @(posedge clk_i);
    if (board.errors == 0 && board.due_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/sast_pkg.sv
design/sast_isqrt.sv
design/sast_div.sv
design/stepper_accel_step_timer_core.sv
verif/testbench.sv
